// ----- rtl/dem_pkg.sv -----
// shared types, widths and constants of the disparity error metrics block
// no dependencies
`timescale 1ns / 1ps

package dem_pkg;

  localparam int DISP_W          = 16;
  localparam int FRAC_BITS       = 4;
  localparam int MAX_PIXELS_LOG2 = 22;
  localparam int COUNT_W         = 23;
  localparam int SUM_W           = 55;
  localparam int PCT_W           = 14;
  localparam int RMS_W           = 24;
  localparam int ERR_W           = DISP_W + 1;
  localparam int SQ_ERR_W        = 2 * ERR_W;

  // rms is taken of sum * 2^RMS_SHIFT / n so the root lands in 1/256 pixel
  localparam int RMS_SHIFT = 16 - 2 * FRAC_BITS;
  localparam int DIV_W     = SUM_W + RMS_SHIFT;
  localparam int ROOT_W    = (DIV_W + 1) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int STEP_W    = $clog2(DIV_W);

  localparam int PCT_SCALE_VAL = 10000;
  localparam int PROD_W        = COUNT_W + PCT_W;

  localparam logic [COUNT_W-1:0] PIXEL_CAP =
    (MAX_PIXELS_LOG2 >= COUNT_W) ? {COUNT_W{1'b1}} : COUNT_W'(1 << MAX_PIXELS_LOG2);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_THRESH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_EN   = 2'd3;

  localparam logic [DISP_W-1:0] BAD_THRESH_RST = DISP_W'(16);

  typedef struct packed {
    logic signed [DISP_W-1:0] est_disp;
    logic signed [DISP_W-1:0] gt_disp;
    logic                     est_finite;
    logic                     gt_finite;
    logic                     last_pixel;
  } dem_in_t;

  typedef struct packed {
    logic               has_valid;
    logic [COUNT_W-1:0] valid_count;
    logic [COUNT_W-1:0] bad_count;
    logic [PCT_W-1:0]   bad_percent;
    logic [RMS_W-1:0]   rms_error;
  } dem_res_t;

  typedef struct packed {
    logic signed [DISP_W-1:0] range_min;
    logic signed [DISP_W-1:0] range_max;
    logic [DISP_W-1:0]        bad_threshold;
    logic                     range_filter_enable;
  } dem_cfg_t;

  // frame totals handed from the front to the back
  typedef struct packed {
    logic [COUNT_W-1:0] count_valid;
    logic [COUNT_W-1:0] count_bad;
    logic [SUM_W-1:0]   sum_squares;
  } dem_snap_t;

  typedef struct packed {
    logic      valid;
    dem_snap_t snap;
  } dem_snap_push_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } dem_qstat_t;

endpackage

// ----- rtl/dem_front.sv -----
// front part: pixel classification, squared error and frame accumulation
// depends on dem_pkg
`timescale 1ns / 1ps

module dem_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  dem_pkg::dem_in_t        pix_i,
  input  dem_pkg::dem_cfg_t       cfg_i,
  output dem_pkg::dem_snap_push_t push_o,
  output logic [1:0]              pending_o
);
  import dem_pkg::*;

  logic signed [ERR_W-1:0] diff;
  logic [ERR_W-1:0]        err;
  logic                    filt_on, in_range, take;

  logic                s1_valid_q, s1_take_q, s1_bad_q, s1_last_q;
  logic [ERR_W-1:0]    s1_err_q;
  logic                s2_valid_q, s2_take_q, s2_bad_q, s2_last_q;
  logic [SQ_ERR_W-1:0] s2_sq_q;

  logic [COUNT_W-1:0] cnt_q, bad_q, cnt_n, bad_n;
  logic [SUM_W-1:0]   sum_q, sum_n;
  logic               inc;

  // stage 1: classify
  always_comb begin
    diff     = ERR_W'(pix_i.est_disp) - ERR_W'(pix_i.gt_disp);
    err      = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
    filt_on  = cfg_i.range_filter_enable && (cfg_i.range_max > cfg_i.range_min);
    in_range = (pix_i.est_disp >= cfg_i.range_min) && (pix_i.est_disp <= cfg_i.range_max);
    take     = pix_i.gt_finite && (pix_i.gt_disp > 0) && pix_i.est_finite &&
               (pix_i.est_disp > 0) && (!filt_on || in_range);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_take_q <= take;
    s1_bad_q  <= err > ERR_W'(cfg_i.bad_threshold);
    s1_last_q <= pix_i.last_pixel;
    s1_err_q  <= err;
    // stage 2: square
    s2_take_q <= s1_take_q;
    s2_bad_q  <= s1_bad_q;
    s2_last_q <= s1_last_q;
    s2_sq_q   <= SQ_ERR_W'(s1_err_q) * SQ_ERR_W'(s1_err_q);
  end

  // stage 3: accumulate, pixels beyond the cap are dropped
  always_comb begin
    inc   = s2_take_q && (cnt_q < PIXEL_CAP);
    cnt_n = cnt_q + COUNT_W'(inc);
    bad_n = bad_q + COUNT_W'(inc && s2_bad_q);
    sum_n = sum_q + (inc ? SUM_W'(s2_sq_q) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      bad_q <= '0;
      sum_q <= '0;
    end else if (s2_valid_q) begin
      if (s2_last_q) begin
        cnt_q <= '0;
        bad_q <= '0;
        sum_q <= '0;
      end else begin
        cnt_q <= cnt_n;
        bad_q <= bad_n;
        sum_q <= sum_n;
      end
    end
  end

  assign push_o.valid            = s2_valid_q && s2_last_q;
  assign push_o.snap.count_valid = cnt_n;
  assign push_o.snap.count_bad   = bad_n;
  assign push_o.snap.sum_squares = sum_n;

  assign pending_o = 2'(s1_valid_q && s1_last_q) + 2'(s2_valid_q && s2_last_q);

endmodule

// ----- rtl/dem_snap_fifo.sv -----
// short queue of frame totals between the front and the back
// depends on dem_pkg
`timescale 1ns / 1ps

module dem_snap_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dem_pkg::dem_snap_push_t push_i,
  input  logic                    pop_i,
  output dem_pkg::dem_snap_t      head_o,
  output dem_pkg::dem_qstat_t     stat_o
);
  import dem_pkg::*;

  dem_snap_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.snap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push_i.valid) - QCNT_W'(do_pop);
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

// ----- rtl/dem_back.sv -----
// back part: shared bit-serial divider, digit-serial square root, result register
// depends on dem_pkg
`timescale 1ns / 1ps

module dem_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dem_pkg::dem_qstat_t qstat_i,
  input  dem_pkg::dem_snap_t  head_i,
  output logic                qpop_o,
  input  logic                pop_i,
  output logic                res_valid_o,
  output dem_pkg::dem_res_t   res_o
);
  import dem_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIVP = 3'd2;
  localparam logic [2:0] ST_DIVR = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [COUNT_W-1:0] n_q, bad_q;
  logic [SUM_W-1:0]   sum_q;
  logic [DIV_W-1:0]   dvd_q, dvd_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [PCT_W-1:0]   pct_q, pct_d;
  logic [RAD_W-1:0]   rad_q, rad_d;
  logic [ROOT_W+1:0]  srem_q, srem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic               out_valid_q;
  dem_res_t           out_q;

  // divider step
  logic [COUNT_W:0]   rem_sh;
  logic               q_bit;
  logic [COUNT_W-1:0] rem_n;
  logic [DIV_W-1:0]   dvd_n;
  // root step
  logic [ROOT_W+3:0]  srem_sh, trial;
  logic               r_bit;
  logic [ROOT_W+1:0]  srem_n;
  logic [ROOT_W-1:0]  root_n;
  logic [PROD_W-1:0]  prod;
  logic               out_free;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DIV_W-1]};
    q_bit   = rem_sh >= {1'b0, n_q};
    rem_n   = q_bit ? COUNT_W'(rem_sh - {1'b0, n_q}) : rem_sh[COUNT_W-1:0];
    dvd_n   = {dvd_q[DIV_W-2:0], q_bit};

    srem_sh = {srem_q, rad_q[RAD_W-1 -: 2]};
    trial   = (ROOT_W+4)'({root_q, 2'b01});
    r_bit   = srem_sh >= trial;
    srem_n  = r_bit ? (ROOT_W+2)'(srem_sh - trial) : srem_sh[ROOT_W+1:0];
    root_n  = {root_q[ROOT_W-2:0], r_bit};

    prod    = PROD_W'(bad_q) * PROD_W'(PCT_SCALE_VAL);
  end

  assign out_free = !out_valid_q || pop_i;
  assign qpop_o   = (state_q == ST_IDLE) && !qstat_i.empty;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    pct_d   = pct_q;
    rad_d   = rad_q;
    srem_d  = srem_q;
    root_d  = root_q;
    unique case (state_q)
      ST_IDLE: begin
        pct_d  = '0;
        root_d = '0;
        if (!qstat_i.empty) begin
          state_d = (head_i.count_valid == '0) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        dvd_d   = DIV_W'(prod);
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIVP;
      end
      ST_DIVP: begin
        dvd_d  = dvd_n;
        rem_d  = rem_n;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_W - 1)) begin
          pct_d   = dvd_n[PCT_W-1:0];
          dvd_d   = {sum_q, {RMS_SHIFT{1'b0}}};
          rem_d   = '0;
          step_d  = '0;
          state_d = ST_DIVR;
        end
      end
      ST_DIVR: begin
        dvd_d  = dvd_n;
        rem_d  = rem_n;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_W - 1)) begin
          rad_d   = RAD_W'(dvd_n);
          srem_d  = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rad_d  = {rad_q[RAD_W-3:0], 2'b00};
        srem_d = srem_n;
        root_d = root_n;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(ROOT_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    pct_q  <= pct_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    if (qpop_o) begin
      n_q   <= head_i.count_valid;
      bad_q <= head_i.count_bad;
      sum_q <= head_i.sum_squares;
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_q.has_valid   <= (n_q != '0);
      out_q.valid_count <= n_q;
      out_q.bad_count   <= bad_q;
      out_q.bad_percent <= pct_q;
      out_q.rms_error   <= root_q[RMS_W-1:0];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- rtl/disparity_error_metrics.sv -----
// top level of the disparity error metrics block: configuration registers,
// queue-style ports and the front / queue / back split; depends on dem_pkg,
// dem_front, dem_snap_fifo and dem_back
`timescale 1ns / 1ps

// throughput: one pixel per cycle into the front while full is low; full rises only
//   while two frame results are queued or in flight ahead of the back
// back: the shared one-bit-per-cycle divider (63 steps, used twice) and the 32-step
//   root give the percentage and the rms of each frame
// reset: asynchronous, clears the accumulators, the queue and the result valid flag;
//   configuration comes back as range 0..0, threshold 16, filter off
module disparity_error_metrics (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pixel side
  input  logic                               push,
  output logic                               full,
  input  dem_pkg::dem_in_t                   in_i,
  // result side
  output logic                               empty,
  input  logic                               pop,
  output dem_pkg::dem_res_t                  res_o,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dem_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dem_pkg::DISP_W-1:0]         cfg_data_i
);
  import dem_pkg::*;

  dem_cfg_t       cfg_q;
  dem_snap_push_t snap_push;
  dem_snap_t      snap_head;
  dem_qstat_t     qstat;
  logic [1:0]     pending;
  logic           accept, qpop, res_valid;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_min           <= '0;
      cfg_q.range_max           <= '0;
      cfg_q.bad_threshold       <= BAD_THRESH_RST;
      cfg_q.range_filter_enable <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RANGE_MIN:  cfg_q.range_min           <= cfg_data_i;
        REG_RANGE_MAX:  cfg_q.range_max           <= cfg_data_i;
        REG_BAD_THRESH: cfg_q.bad_threshold       <= cfg_data_i;
        REG_RANGE_EN:   cfg_q.range_filter_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // a queue slot is reserved for every frame end still inside the front pipeline,
  // so the front never has to stall once a pixel is taken
  assign full   = (3'(qstat.count) + 3'(pending)) >= 3'(QUEUE_DEPTH);
  assign accept = push && !full;

  // front: classify each pixel, square its error, accumulate frame totals
  dem_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .pix_i     (in_i),
    .cfg_i     (cfg_q),
    .push_o    (snap_push),
    .pending_o (pending)
  );

  // frame totals wait here while the back is busy with an earlier frame
  dem_snap_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (snap_push),
    .pop_i  (qpop),
    .head_o (snap_head),
    .stat_o (qstat)
  );

  // back: percentage and rms through the shared divider and root unit
  dem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .head_i      (snap_head),
    .qpop_o      (qpop),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res_o)
  );

  assign empty = !res_valid;

  // a frame end is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_push.valid |-> (qstat.count != QCNT_W'(QUEUE_DEPTH)))
    else $error("frame totals pushed into a full queue");

  // the result says it has pixels exactly when its count is non-zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_o.has_valid == (res_o.valid_count != '0)))
    else $error("has_valid disagrees with valid_count");

  // bad pixels are a subset of counted pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_o.bad_count <= res_o.valid_count))
    else $error("bad_count above valid_count");

  // percentage in hundredths of a percent never exceeds one hundred percent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_o.bad_percent <= PCT_W'(PCT_SCALE_VAL)))
    else $error("bad_percent out of range");

  // a waiting result holds until it is popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("result changed before pop");

endmodule

// ----- sim/dem_checker.sv -----
// frame metrics checker: watches the pixel, result and configuration channels,
// keeps its own frame totals and compares every popped result; depends on dem_pkg
`timescale 1ns / 1ps

module dem_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          full_i,
  input  dem_pkg::dem_in_t              pix_i,
  input  logic                          empty_i,
  input  logic                          pop_i,
  input  dem_pkg::dem_res_t             res_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [dem_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dem_pkg::DISP_W-1:0]    cfg_data_i,
  output int                            err_cnt_o,
  output int                            pending_o
);
  import dem_pkg::*;

  dem_cfg_t           cfg_q;
  logic [COUNT_W-1:0] n_valid;
  logic [COUNT_W-1:0] n_bad;
  logic [SUM_W-1:0]   sq_sum;
  dem_res_t           metrics_due[$];
  int                 mismatches;

  // largest r with r * r <= x, one bit at a time from the top
  function automatic logic [31:0] floor_root(logic [63:0] x);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (64'(c) * 64'(c) <= x) r = c;
    end
    return r;
  endfunction

  function automatic dem_res_t frame_metrics(logic [COUNT_W-1:0] nv, logic [COUNT_W-1:0] nb,
                                             logic [SUM_W-1:0] ss);
    dem_res_t    m;
    logic [63:0] mean_sq;
    m = '0;
    m.valid_count = nv;
    m.bad_count   = nb;
    if (nv != 0) begin
      // floor(ss * 256 / n): mean square in 1/65536 pixel^2
      mean_sq       = (64'(ss) << RMS_SHIFT) / 64'(nv);
      m.has_valid   = 1'b1;
      m.bad_percent = PCT_W'((64'(nb) * 64'd10000) / 64'(nv));
      m.rms_error   = RMS_W'(floor_root(mean_sq));
    end
    return m;
  endfunction

  function automatic logic pixel_qualifies(dem_in_t px, dem_cfg_t c);
    logic keep;
    keep = px.est_finite && px.gt_finite && (px.est_disp > 0) && (px.gt_disp > 0);
    // range filter only bites on a non-empty range
    if (keep && c.range_filter_enable && (c.range_max > c.range_min) &&
        ((px.est_disp < c.range_min) || (px.est_disp > c.range_max)))
      keep = 1'b0;
    return keep;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dem_res_t    want;
    int          diff;
    logic [31:0] mag;
    if (!rst_ni) begin
      cfg_q.range_min           = '0;
      cfg_q.range_max           = '0;
      cfg_q.bad_threshold       = BAD_THRESH_RST;
      cfg_q.range_filter_enable = 1'b0;
      n_valid    = '0;
      n_bad      = '0;
      sq_sum     = '0;
      mismatches = 0;
      metrics_due.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_RANGE_MIN:  cfg_q.range_min           = cfg_data_i;
          REG_RANGE_MAX:  cfg_q.range_max           = cfg_data_i;
          REG_BAD_THRESH: cfg_q.bad_threshold       = cfg_data_i;
          REG_RANGE_EN:   cfg_q.range_filter_enable = cfg_data_i[0];
          default: ;
        endcase
      end

      // compare before adding, a result never leaves on the edge of its own last pixel
      if (!empty_i && pop_i) begin
        if (metrics_due.size() == 0) begin
          $error("result transaction with no frame awaiting it");
          mismatches++;
        end else begin
          want = metrics_due.pop_front();
          check_field("has_valid", want.has_valid, res_i.has_valid);
          check_field("valid_count", want.valid_count, res_i.valid_count);
          check_field("bad_count", want.bad_count, res_i.bad_count);
          check_field("bad_percent", want.bad_percent, res_i.bad_percent);
          check_field("rms_error", want.rms_error, res_i.rms_error);
        end
      end

      if (push_i && !full_i) begin
        if (pixel_qualifies(pix_i, cfg_q) && (n_valid < PIXEL_CAP)) begin
          diff = int'(pix_i.est_disp) - int'(pix_i.gt_disp);
          mag  = (diff < 0) ? -diff : diff;
          n_valid++;
          if (mag > cfg_q.bad_threshold) n_bad++;
          sq_sum += SUM_W'(64'(mag) * 64'(mag));
        end
        if (pix_i.last_pixel) begin
          metrics_due.push_back(frame_metrics(n_valid, n_bad, sq_sum));
          n_valid = '0;
          n_bad   = '0;
          sq_sum  = '0;
        end
      end

      err_cnt_o <= mismatches;
      pending_o <= metrics_due.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// testbench top for disparity_error_metrics: clock, reset, pixel frames,
// configuration phases and random pop stalls; depends on dem_pkg and dem_checker
`timescale 1ns / 1ps

module tb;
  import dem_pkg::*;

  localparam int      RESET_CYCLES  = 8;
  localparam int      PIXEL_TARGET  = 850;
  // margin left after the last result has been popped
  localparam int      SETTLE_CYCLES = 220;
  localparam longint  CYCLE_LIMIT   = 1000000;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  dem_in_t              pix_in    = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  dem_res_t             metrics;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DISP_W-1:0]    cfg_data  = '0;

  int       err_cnt;
  int       pending;
  longint   cycle_cnt = 0;
  dem_cfg_t cfg_now;         // what the block holds, used only to shape stimulus
  logic     no_gaps   = 1'b0;
  logic     pop_eager = 1'b0;
  int       pop_hold  = 0;

  disparity_error_metrics uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (pix_in),
    .empty       (empty),
    .pop         (pop),
    .res_o       (metrics),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dem_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .pix_i       (pix_in),
    .empty_i     (empty),
    .pop_i       (pop),
    .res_i       (metrics),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: mostly ready, short stalls, the odd long one; eager phases never stall
  always @(posedge clk_i) begin
    int roll;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_eager) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        pop <= 1'b1;
      end else if (roll < 93) begin
        pop      <= 1'b0;
        pop_hold = $urandom_range(0, 2);
      end else begin
        pop      <= 1'b0;
        pop_hold = $urandom_range(15, 70);
      end
    end
  end

  // gap after a transaction on the pixel or configuration side
  function automatic int idle_len();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // push stays high from one pixel to the next unless a gap follows
  task automatic put_pixel(dem_in_t px);
    int gap;
    push   <= 1'b1;
    pix_in <= px;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [DISP_W-1:0] data);
    int gap;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    gap = idle_len();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until every frame result has been popped and the back stage has drained
  task automatic quiesce();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // all four registers, starting at a random index
  task automatic set_config(dem_cfg_t c);
    logic [CFG_IDX_W-1:0] idx;
    idx = CFG_IDX_W'($urandom_range(0, 3));
    repeat (4) begin
      case (idx)
        REG_RANGE_MIN:  put_reg(REG_RANGE_MIN, c.range_min);
        REG_RANGE_MAX:  put_reg(REG_RANGE_MAX, c.range_max);
        REG_BAD_THRESH: put_reg(REG_BAD_THRESH, c.bad_threshold);
        default:        put_reg(REG_RANGE_EN, {{(DISP_W-1){1'b0}}, c.range_filter_enable});
      endcase
      idx++;
    end
    cfg_valid <= 1'b0;
    cfg_now = c;
  endtask

  function automatic dem_cfg_t make_cfg(int lo, int hi, int thr, logic en);
    dem_cfg_t c;
    c.range_min           = DISP_W'(lo);
    c.range_max           = DISP_W'(hi);
    c.bad_threshold       = DISP_W'(thr);
    c.range_filter_enable = en;
    return c;
  endfunction

  function automatic dem_cfg_t pick_config();
    int lo;
    int hi;
    int thr;
    case ($urandom_range(0, 5))
      0: begin lo = -32768; hi = 32767;  end
      1: begin lo = 32767;  hi = -32768; end   // inverted, filter stays off
      default: begin
        lo = int'($urandom_range(0, 3000)) - 200;
        hi = lo + int'($urandom_range(0, 3000)) - 300;
      end
    endcase
    case ($urandom_range(0, 5))
      0:       thr = 0;
      1:       thr = 65535;
      default: thr = $urandom_range(0, 400);
    endcase
    return make_cfg(lo, hi, thr, $urandom_range(0, 3) != 0);
  endfunction

  function automatic dem_in_t pixel(int est, int gt, logic ef, logic gf, logic last);
    dem_in_t px;
    px.est_disp   = DISP_W'(est);
    px.gt_disp    = DISP_W'(gt);
    px.est_finite = ef;
    px.gt_finite  = gf;
    px.last_pixel = last;
    return px;
  endfunction

  // mostly well-formed pairs aimed at the threshold and range edges, plus some noise
  function automatic dem_in_t make_pixel(logic last, int noise_pct);
    dem_in_t px;
    int      gt;
    int      est;
    int      thr;
    case ($urandom_range(0, 19))
      0, 1, 2:             gt = ($urandom_range(0, 1) != 0) ? 1 : 32767;
      3, 4, 5, 6, 7, 8, 9: gt = $urandom_range(1, 32767);
      default:             gt = $urandom_range(1, 2047);
    endcase
    thr = int'(cfg_now.bad_threshold);
    case ($urandom_range(0, 9))
      0, 1, 2: est = gt + int'($urandom_range(0, 64)) - 32;
      3, 4:    est = $urandom_range(1, 32767);
      5:       est = $urandom_range(1, 255);
      6, 7:    est = (($urandom_range(0, 1) != 0) ? int'(cfg_now.range_min)
                                                  : int'(cfg_now.range_max))
                     + int'($urandom_range(0, 2)) - 1;
      default: est = gt + (($urandom_range(0, 1) != 0) ? thr : -thr)
                     + int'($urandom_range(0, 2)) - 1;
    endcase
    px = pixel(est, gt, 1'b1, 1'b1, last);
    if (int'($urandom_range(0, 99)) < noise_pct) begin
      case ($urandom_range(0, 5))
        0:       px.est_disp   = DISP_W'($urandom);
        1:       px.gt_disp    = DISP_W'($urandom);
        2:       px.est_finite = 1'b0;
        3:       px.gt_finite  = 1'b0;
        4:       px.est_disp   = '0;
        default: px.gt_disp    = '0;
      endcase
    end
    return px;
  endfunction

  function automatic int frame_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, 20);
    if (roll < 97) return $urandom_range(21, 80);
    return $urandom_range(150, 300);
  endfunction

  initial begin
    int random_sent;
    int phase_goal;
    int phase_sent;
    int len;
    int noise;

    cfg_now = make_cfg(0, 0, int'(BAD_THRESH_RST), 1'b0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: threshold 16, filter off
    // frame with no counted pixel gives an all-zero result
    put_pixel(pixel(5, 5, 1'b0, 1'b1, 1'b1));
    put_pixel(pixel(1, 1, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(32767, 1, 1'b1, 1'b1, 1'b0));     // largest error
    put_pixel(pixel(1, 32767, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(17, 1, 1'b1, 1'b1, 1'b0));        // error equal to threshold, not bad
    put_pixel(pixel(18, 1, 1'b1, 1'b1, 1'b0));        // one above, bad
    put_pixel(pixel(0, 5, 1'b1, 1'b1, 1'b0));         // zero estimate skipped
    put_pixel(pixel(5, 0, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(-32768, 5, 1'b1, 1'b1, 1'b0));    // negative skipped
    put_pixel(pixel(5, -1, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(7, 7, 1'b1, 1'b0, 1'b0));         // unknown ground truth
    put_pixel(pixel(32767, 32767, 1'b1, 1'b1, 1'b1));
    put_pixel(pixel(1, 1, 1'b1, 1'b1, 1'b1));         // single pixel frame

    // range filter on a proper range, zero threshold
    quiesce();
    set_config(make_cfg(16, 512, 0, 1'b1));
    put_pixel(pixel(15, 20, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(16, 20, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(512, 20, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(513, 20, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(100, 100, 1'b1, 1'b1, 1'b1));

    // inverted range leaves the filter off, top threshold never reached
    quiesce();
    set_config(make_cfg(300, 100, 65535, 1'b1));
    put_pixel(pixel(50, 40, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(1000, 40, 1'b1, 1'b1, 1'b0));
    put_pixel(pixel(20000, 1, 1'b1, 1'b1, 1'b1));

    // equal bounds count as empty too
    quiesce();
    set_config(make_cfg(100, 100, 16, 1'b1));
    put_pixel(pixel(5, 6, 1'b1, 1'b1, 1'b1));

    // random phases, each with its own configuration and handshake pressure
    random_sent = 0;
    while (random_sent < PIXEL_TARGET) begin
      quiesce();
      set_config(pick_config());
      no_gaps    = ($urandom_range(0, 3) == 0);
      pop_eager  = ($urandom_range(0, 4) == 0);
      phase_goal = $urandom_range(80, 180);
      phase_sent = 0;
      while (phase_sent < phase_goal) begin
        len   = frame_len();
        noise = ($urandom_range(0, 9) == 0) ? 100 : 12;
        for (int i = 0; i < len; i++)
          put_pixel(make_pixel(i == len - 1, noise));
        phase_sent += len;
      end
      random_sent += phase_sent;
    end

    quiesce();
    if (err_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dem_pkg.sv
rtl/dem_front.sv
rtl/dem_snap_fifo.sv
rtl/dem_back.sv
rtl/disparity_error_metrics.sv
sim/dem_checker.sv
sim/tb.sv
